// ===== hdl/wildcard_byte_pattern_scan_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern scan core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WBPS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("wbps assertion failed");

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("wbps assertion failed");

`else

`define WBPS_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define WBPS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== hdl/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Types and constants shared by the wildcard byte pattern scan core.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES   = 16;
    localparam int OFFSET_BITS         = 32;
    localparam int CFG_DATA_BITS       = 64;
    localparam int CFG_INDEX_BITS      = 2;
    localparam int PATTERN_LENGTH_BITS = 5;
    localparam int CARE_BITS           = 16;
    localparam int PATTERN_BYTES_TOTAL = 16;
    localparam int MATCH_OFFSET_BITS   = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_CARE_MASK      = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic                         found;
        logic [MATCH_OFFSET_BITS-1:0] match_offset;
    } result_t;

endpackage

// ===== hdl/wbps_match.sv =====
// ----------------------------------------------------------------------------
// wbps_match
// Masked compare of the byte history against the pattern bytes in use.
// ----------------------------------------------------------------------------
module wbps_match #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES
) (
    input  logic [7:0]                                      newest,
    input  logic [((MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1)-1:0][7:0] window,
    input  logic [MAX_PATTERN_BYTES-1:0][7:0]               pattern,
    input  logic [MAX_PATTERN_BYTES-1:0]                    care,
    input  logic [$clog2(MAX_PATTERN_BYTES + 1)-1:0]        len,
    output logic                                            hit
);

    localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    // history by age: age 0 is the byte being transferred now
    logic [MAX_PATTERN_BYTES-1:0][7:0] hist;
    logic [MAX_PATTERN_BYTES-1:0]      byte_ok;

    always_comb
    begin
        hist[0] = newest;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
        begin
            hist[k] = window[k-1];
        end
    end

    // pattern byte j lines up with the byte of age len-1-j
    always_comb
    begin
        logic [LEN_BITS-1:0] age;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            age = LEN_BITS'(len - LEN_BITS'(1) - LEN_BITS'(j));
            if (LEN_BITS'(j) >= len || !care[j])
            begin
                byte_ok[j] = 1'b1;
            end
            else
            begin
                byte_ok[j] = (hist[age[IDX_BITS-1:0]] == pattern[j]);
            end
        end
    end

    assign hit = &byte_ok;

endmodule

// ===== hdl/wildcard_byte_pattern_scan_core.sv =====
// Latency: a result is presented on the cycle after the transfer of the byte that causes it.
// Throughput: one byte per cycle while input is not stalled; the masked window compare and the offset subtract
// sit between the byte transfer and the result register.
// A held result stalls input only while the result register is full and not taken.
// Reset (rst_n low, asynchronous): pattern and care mask clear, length 1, scan cleared.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_core
// Streams region bytes and reports the first offset where a wildcard pattern
// matches, or not found at the last byte of the region.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_core_defines.svh"

module wildcard_byte_pattern_scan_core #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = wbps_pkg::OFFSET_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  wbps_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output wbps_pkg::result_t                   result
);

    localparam int LEN_BITS  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WIN_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
    localparam int WIDE_BITS = (OFFSET_BITS > wbps_pkg::MATCH_OFFSET_BITS) ?
                               OFFSET_BITS : wbps_pkg::MATCH_OFFSET_BITS;

    // configuration registers
    logic [wbps_pkg::CFG_DATA_BITS-1:0]       pattern_low_reg;
    logic [wbps_pkg::CFG_DATA_BITS-1:0]       pattern_high_reg;
    logic [wbps_pkg::CARE_BITS-1:0]           care_mask_reg;
    logic [wbps_pkg::PATTERN_LENGTH_BITS-1:0] pattern_length_reg;

    // scan state
    logic [WIN_DEPTH-1:0][7:0] window_reg;
    logic [WIN_DEPTH-1:0][7:0] window_next;
    logic [OFFSET_BITS-1:0]    bytes_seen_reg;
    logic [OFFSET_BITS-1:0]    bytes_seen_next;
    logic                      match_reported_reg;
    logic                      match_reported_next;

    // result register
    wbps_pkg::result_t result_reg;
    wbps_pkg::result_t result_next;
    logic              result_valid_reg;
    logic              result_valid_next;

    logic                                          accept;
    logic                                          saturated;
    logic [LEN_BITS-1:0]                           len_used;
    logic [OFFSET_BITS-1:0]                        count;
    logic [OFFSET_BITS-1:0]                        offset_full;
    logic [WIDE_BITS-1:0]                          offset_wide;
    logic [wbps_pkg::PATTERN_BYTES_TOTAL-1:0][7:0] pattern_all;
    logic                                          window_hit;
    logic                                          match_now;
    logic                                          not_found_now;

    // ------------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= wbps_pkg::PATTERN_LENGTH_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (wbps_pkg::cfg_index_t'(cfg_index))
                wbps_pkg::CFG_PATTERN_LOW:    pattern_low_reg  <= cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg <= cfg_data;
                wbps_pkg::CFG_CARE_MASK:      care_mask_reg    <= cfg_data[wbps_pkg::CARE_BITS-1:0];
                wbps_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[wbps_pkg::PATTERN_LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp the length to 1..MAX_PATTERN_BYTES
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_used = LEN_BITS'(1);
        end
        else if (pattern_length_reg > wbps_pkg::PATTERN_LENGTH_BITS'(MAX_PATTERN_BYTES))
        begin
            len_used = LEN_BITS'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_used = LEN_BITS'(pattern_length_reg);
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    wbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .newest  (item.data_byte),
        .window  (window_reg),
        .pattern (pattern_all[MAX_PATTERN_BYTES-1:0]),
        .care    (care_mask_reg[MAX_PATTERN_BYTES-1:0]),
        .len     (len_used),
        .hit     (window_hit)
    );

    // ------------------------------------------------------------------------
    // per-byte decision
    // ------------------------------------------------------------------------
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign saturated  = &bytes_seen_reg;
    assign count      = bytes_seen_reg + OFFSET_BITS'(1);
    assign offset_full = count - OFFSET_BITS'(len_used);
    assign offset_wide = WIDE_BITS'(offset_full);

    // a byte past the saturated count lies beyond the offset range
    assign match_now = !match_reported_reg && !saturated &&
                       (count >= OFFSET_BITS'(len_used)) && window_hit;
    assign not_found_now = item.last_byte && !match_now && !match_reported_reg;

    always_comb
    begin
        window_next[0] = item.data_byte;
        for (int k = 1; k < WIN_DEPTH; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    always_comb
    begin
        bytes_seen_next     = bytes_seen_reg;
        match_reported_next = match_reported_reg;
        if (accept)
        begin
            if (item.last_byte)
            begin
                // clear for the next region
                bytes_seen_next     = '0;
                match_reported_next = 1'b0;
            end
            else
            begin
                if (!saturated)
                begin
                    bytes_seen_next = count;
                end
                if (match_now)
                begin
                    match_reported_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (accept && (match_now || not_found_now))
        begin
            result_valid_next        = 1'b1;
            result_next.found        = match_now;
            result_next.match_offset = match_now ?
                offset_wide[wbps_pkg::MATCH_OFFSET_BITS-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg     <= '0;
            match_reported_reg <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            bytes_seen_reg     <= bytes_seen_next;
            match_reported_reg <= match_reported_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    // window and result payload hold unless a byte is transferred
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg <= window_next;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `WBPS_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && item.last_byte, (bytes_seen_reg == '0) && !match_reported_reg)
    `WBPS_ASSERT_NOW(a_not_found_zero, clk, rst_n, result_valid_reg && !result_reg.found, result_reg.match_offset == '0)
    `WBPS_ASSERT_NEXT(a_reported_sticks, clk, rst_n, accept && match_reported_reg && !item.last_byte, match_reported_reg)
    `WBPS_ASSERT_NEXT(a_count_grows, clk, rst_n, accept && !item.last_byte, bytes_seen_reg >= $past(bytes_seen_reg))
    `WBPS_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !result_valid_reg, item_ready)

endmodule
